// ===== rtl/core/wilder_rsi_indicator_unit_macros.svh =====
// assertion macros for the wilder rsi indicator unit checker
// no dependencies; included by the checker file
`ifndef WILDER_RSI_INDICATOR_UNIT_MACROS_SVH
`define WILDER_RSI_INDICATOR_UNIT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define WRSI_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// clocked assertion that also holds across reset
`define WRSI_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/wrsi_pkg.sv =====
// shared widths, constants and types of the wilder rsi indicator unit
// no dependencies; used by the interfaces, the divider, the top level and the checker
package wrsi_pkg;

   // field and state widths
   localparam int PRICE_BITS    = 32;
   localparam int FRACTION_BITS = 16;
   localparam int AVG_BITS      = 64;
   localparam int PERIOD_BITS   = 16;
   localparam int DATE_BITS     = 32;
   localparam int RSI_BITS      = 23;

   // serial divider: averages plus fraction bits, one quotient bit per cycle
   localparam int DIV_BITS       = AVG_BITS + FRACTION_BITS;
   localparam int DIV_COUNT_BITS = $clog2(DIV_BITS + 1);

   // rsi long division steps, one per bit of the full scale constant
   localparam int RSI_STEPS = RSI_BITS;
   localparam int STEP_BITS = $clog2(RSI_STEPS);

   // 100 percent and 50 percent in units of 1/65536 percent
   localparam logic [RSI_BITS-1:0] RSI_FULL = RSI_BITS'(6553600);
   localparam logic [RSI_BITS-1:0] RSI_HALF = RSI_BITS'(3276800);

   localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = PERIOD_BITS'(14);

   // divider result seen by the sequencer
   typedef struct packed {
      logic                   done;
      logic [DIV_BITS-1:0]    quotient;
      logic [PERIOD_BITS-1:0] remainder;
   } div_result_type;

endpackage

// ===== rtl/core/wrsi_channels.sv =====
// valid/ready channel interfaces of the wilder rsi indicator unit
// depends on wrsi_pkg for the payload widths

// bar input channel
interface wrsi_req_if;
   logic                             valid;
   logic                             ready;
   logic [31:0]                      close_price;
   logic [wrsi_pkg::DATE_BITS-1:0]   bar_date;
   logic                             series_start;

   modport source (output valid, output close_price, output bar_date,
                   output series_start, input ready);
   modport sink (input valid, input close_price, input bar_date,
                 input series_start, output ready);
endinterface

// rsi result channel
interface wrsi_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [wrsi_pkg::RSI_BITS-1:0]    rsi_value;
   logic                             rsi_valid;
   logic [wrsi_pkg::DATE_BITS-1:0]   date_out;

   modport source (output valid, output rsi_value, output rsi_valid,
                   output date_out, input ready);
   modport sink (input valid, input rsi_value, input rsi_valid,
                 input date_out, output ready);
endinterface

// smoothing period write channel
interface wrsi_csr_if;
   logic                             valid;
   logic                             ready;
   logic [wrsi_pkg::PERIOD_BITS-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/wrsi_serdiv.sv =====
// restoring serial divider, one quotient bit per cycle, narrow remainder
// depends on wrsi_pkg for widths and the result struct
module wrsi_serdiv (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [wrsi_pkg::DIV_BITS-1:0]    dividend,
   input  logic [wrsi_pkg::PERIOD_BITS-1:0] divisor,
   output wrsi_pkg::div_result_type         result
);

   logic [wrsi_pkg::DIV_BITS-1:0]       work_ff, work_in;
   logic [wrsi_pkg::PERIOD_BITS-1:0]    rem_ff, rem_in;
   logic [wrsi_pkg::PERIOD_BITS-1:0]    dvs_ff, dvs_in;
   logic [wrsi_pkg::DIV_COUNT_BITS-1:0] count_ff, count_in;
   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;

   logic [wrsi_pkg::PERIOD_BITS:0]      trial;
   logic [wrsi_pkg::PERIOD_BITS:0]      diff;

   // trial subtract of the divisor from the shifted remainder
   assign trial = {rem_ff, work_ff[wrsi_pkg::DIV_BITS-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   // dividend shifts out at the top while quotient bits shift in below
   always_comb begin
      work_in  = work_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (busy_ff) begin
         work_in  = {work_ff[wrsi_pkg::DIV_BITS-2:0], ~diff[wrsi_pkg::PERIOD_BITS]};
         rem_in   = diff[wrsi_pkg::PERIOD_BITS] ? trial[wrsi_pkg::PERIOD_BITS-1:0]
                                                : diff[wrsi_pkg::PERIOD_BITS-1:0];
         count_in = count_ff - wrsi_pkg::DIV_COUNT_BITS'(1);
         if (count_ff == wrsi_pkg::DIV_COUNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         work_in  = dividend;
         rem_in   = '0;
         dvs_in   = divisor;
         count_in = wrsi_pkg::DIV_COUNT_BITS'(wrsi_pkg::DIV_BITS);
         busy_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      work_ff  <= work_in;
      rem_ff   <= rem_in;
      dvs_ff   <= dvs_in;
      count_ff <= count_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign result.done      = done_ff;
   assign result.quotient  = work_ff;
   assign result.remainder = rem_ff;

endmodule

// ===== rtl/core/wilder_rsi_indicator_unit.sv =====
// top level of the wilder rsi indicator: bar sequencer, averages and rsi division
// depends on wrsi_pkg, the channel interfaces in wrsi_channels and wrsi_serdiv
//
// usage:
//   req_bus carries one bar per transaction: close_price, bar_date, series_start.
//   rsp_bus returns one result per bar: rsi_value, rsi_valid, date_out.
//   csr_bus writes the smoothing period (0 acts as 1); write it only while idle.
// sequence from accepting edge to result valid:
//   a series start passes prep and finish, a warmup bar prep, load and finish,
//   and a bar with no loss skips the sum and the rsi long division. other bars
//   pass setup, the two parallel serial dividers (80 quotient bits one a cycle,
//   plus the done flag), update, overflow check and sum, 26 rsi long division
//   steps (23 quotient bits plus 3 add steps) and the output load; one bar at a
//   time, so the next bar is taken no sooner than the cycle after that load.
// reset:
//   synchronous; the period returns to 14, the history is dropped so the next
//   bar starts a series, and the result register empties.
// stalls:
//   a finished result waits in the output register; the next bar is accepted
//   and worked on meanwhile, and its result waits until the register is free.
module wilder_rsi_indicator_unit (
   input logic        clock,
   input logic        reset,
   wrsi_req_if.sink   req_bus,
   wrsi_rsp_if.source rsp_bus,
   wrsi_csr_if.sink   csr_bus
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_LOAD,
      ST_DIVIDE,
      ST_UPDATE,
      ST_RSI_INIT,
      ST_RSI_SUM,
      ST_RSI_A,
      ST_RSI_B,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      MODE_ACC,
      MODE_FIRST,
      MODE_SMOOTH
   } mode_type;

   state_type                          state_ff, state_in;
   mode_type                           mode_ff, mode_in;
   logic [wrsi_pkg::PERIOD_BITS-1:0]   period_ff, period_in;
   logic [wrsi_pkg::PERIOD_BITS-1:0]   p_ff, p_in;
   logic [wrsi_pkg::PERIOD_BITS-1:0]   bars_ff, bars_in;
   logic [wrsi_pkg::PRICE_BITS-1:0]    price_ff, price_in;
   logic [wrsi_pkg::PRICE_BITS-1:0]    prev_ff, prev_in;
   logic [wrsi_pkg::PRICE_BITS-1:0]    gain_ff, gain_in;
   logic [wrsi_pkg::PRICE_BITS-1:0]    loss_ff, loss_in;
   logic [wrsi_pkg::DATE_BITS-1:0]     date_ff, date_in;
   logic                               restart_ff, restart_in;
   logic                               hist_ff, hist_in;
   logic                               bar_valid_ff, bar_valid_in;
   logic                               gain_up_ff, gain_up_in;
   logic                               loss_up_ff, loss_up_in;
   logic [wrsi_pkg::AVG_BITS-1:0]      avg_gain_ff, avg_gain_in;
   logic [wrsi_pkg::AVG_BITS-1:0]      avg_loss_ff, avg_loss_in;
   logic [wrsi_pkg::AVG_BITS-1:0]      g_ff, g_in;
   logic [wrsi_pkg::AVG_BITS-1:0]      l_ff, l_in;
   logic [wrsi_pkg::AVG_BITS-1:0]      s_ff, s_in;
   logic [wrsi_pkg::AVG_BITS-1:0]      r_ff, r_in;
   logic [wrsi_pkg::RSI_BITS-1:0]      q_ff, q_in;
   logic [wrsi_pkg::STEP_BITS-1:0]     bit_ff, bit_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               rsp_flag_ff, rsp_flag_in;
   logic [wrsi_pkg::RSI_BITS-1:0]      rsp_value_ff, rsp_value_in;
   logic [wrsi_pkg::DATE_BITS-1:0]     rsp_date_ff, rsp_date_in;

   logic                               div_start;
   logic [wrsi_pkg::DIV_BITS-1:0]      div_gain_dvd, div_loss_dvd;
   wrsi_pkg::div_result_type           div_gain_res, div_loss_res;

   logic [wrsi_pkg::AVG_BITS-1:0]      sum_gain, sum_loss;
   logic [wrsi_pkg::AVG_BITS-1:0]      x_gain, x_loss;
   logic [wrsi_pkg::AVG_BITS:0]        up_gain, up_loss;
   logic [wrsi_pkg::AVG_BITS-1:0]      dn_gain, dn_loss;

   // saturating add of a price change to a running sum
   function automatic logic [wrsi_pkg::AVG_BITS-1:0] sat_add(
      input logic [wrsi_pkg::AVG_BITS-1:0]   a,
      input logic [wrsi_pkg::PRICE_BITS-1:0] b
   );
      logic [wrsi_pkg::AVG_BITS:0] sum;
      sum = {1'b0, a} + (wrsi_pkg::AVG_BITS + 1)'(b);
      return sum[wrsi_pkg::AVG_BITS] ? '1 : sum[wrsi_pkg::AVG_BITS-1:0];
   endfunction

   // price change to fixed point, saturating
   function automatic logic [wrsi_pkg::AVG_BITS-1:0] to_fixed(
      input logic [wrsi_pkg::PRICE_BITS-1:0] x
   );
      logic [wrsi_pkg::DIV_BITS-1:0] wide;
      wide = wrsi_pkg::DIV_BITS'(x) << wrsi_pkg::FRACTION_BITS;
      return (wide[wrsi_pkg::DIV_BITS-1:wrsi_pkg::AVG_BITS] != '0)
             ? '1 : wide[wrsi_pkg::AVG_BITS-1:0];
   endfunction

   // divider operands: scaled sums for the first average, distances for smoothing
   always_comb begin
      sum_gain = sat_add(avg_gain_ff, gain_ff);
      sum_loss = sat_add(avg_loss_ff, loss_ff);
      x_gain   = to_fixed(gain_ff);
      x_loss   = to_fixed(loss_ff);
      up_gain  = {1'b0, x_gain} - {1'b0, avg_gain_ff};
      up_loss  = {1'b0, x_loss} - {1'b0, avg_loss_ff};
      dn_gain  = avg_gain_ff - x_gain;
      dn_loss  = avg_loss_ff - x_loss;
      if (mode_ff == MODE_FIRST) begin
         div_gain_dvd = {sum_gain, {wrsi_pkg::FRACTION_BITS{1'b0}}};
         div_loss_dvd = {sum_loss, {wrsi_pkg::FRACTION_BITS{1'b0}}};
      end else begin
         div_gain_dvd = wrsi_pkg::DIV_BITS'(up_gain[wrsi_pkg::AVG_BITS]
                        ? dn_gain : up_gain[wrsi_pkg::AVG_BITS-1:0]);
         div_loss_dvd = wrsi_pkg::DIV_BITS'(up_loss[wrsi_pkg::AVG_BITS]
                        ? dn_loss : up_loss[wrsi_pkg::AVG_BITS-1:0]);
      end
   end

   assign div_start = (state_ff == ST_LOAD) && (mode_ff != MODE_ACC);

   // one serial divider each for gain and loss, run side by side
   wrsi_serdiv u_div_gain (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_gain_dvd),
      .divisor  (p_ff),
      .result   (div_gain_res)
   );

   wrsi_serdiv u_div_loss (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_loss_dvd),
      .divisor  (p_ff),
      .result   (div_loss_res)
   );

   // bar sequencer
   always_comb begin
      logic [wrsi_pkg::AVG_BITS+1:0] twice_r;
      logic [wrsi_pkg::AVG_BITS:0]   r_less_l;
      logic [wrsi_pkg::AVG_BITS:0]   g_plus_l;
      logic [wrsi_pkg::AVG_BITS-1:0] q_gain, q_loss;
      logic                          last_step;

      state_in     = state_ff;
      mode_in      = mode_ff;
      period_in    = period_ff;
      p_in         = p_ff;
      bars_in      = bars_ff;
      price_in     = price_ff;
      prev_in      = prev_ff;
      gain_in      = gain_ff;
      loss_in      = loss_ff;
      date_in      = date_ff;
      restart_in   = restart_ff;
      hist_in      = hist_ff;
      bar_valid_in = bar_valid_ff;
      gain_up_in   = gain_up_ff;
      loss_up_in   = loss_up_ff;
      avg_gain_in  = avg_gain_ff;
      avg_loss_in  = avg_loss_ff;
      g_in         = g_ff;
      l_in         = l_ff;
      s_in         = s_ff;
      r_in         = r_ff;
      q_in         = q_ff;
      bit_in       = bit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_flag_in  = rsp_flag_ff;
      rsp_value_in = rsp_value_ff;
      rsp_date_in  = rsp_date_ff;

      twice_r   = {1'b0, r_ff, 1'b0} - (wrsi_pkg::AVG_BITS + 2)'(s_ff);
      r_less_l  = {1'b0, r_ff} - {1'b0, l_ff};
      g_plus_l  = {1'b0, avg_gain_ff} + {1'b0, avg_loss_ff};
      q_gain    = div_gain_res.quotient[wrsi_pkg::AVG_BITS-1:0];
      q_loss    = div_loss_res.quotient[wrsi_pkg::AVG_BITS-1:0];
      last_step = (bit_ff == '0);

      // period register write
      if (csr_bus.valid) begin
         period_in = csr_bus.data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               price_in   = wrsi_pkg::PRICE_BITS'(req_bus.close_price);
               date_in    = req_bus.bar_date;
               restart_in = req_bus.series_start;
               p_in       = (period_ff == '0) ? wrsi_pkg::PERIOD_BITS'(1) : period_ff;
               state_in   = ST_PREP;
            end
         end
         // new series, or price change and choice of warmup, first average or smoothing
         ST_PREP: begin
            prev_in = price_ff;
            if (restart_ff || !hist_ff) begin
               hist_in      = 1'b1;
               avg_gain_in  = '0;
               avg_loss_in  = '0;
               bars_in      = '0;
               bar_valid_in = 1'b0;
               q_in         = '0;
               state_in     = ST_FINISH;
            end else begin
               gain_in  = (price_ff > prev_ff) ? price_ff - prev_ff : '0;
               loss_in  = (price_ff > prev_ff) ? '0 : prev_ff - price_ff;
               state_in = ST_LOAD;
               if (bars_ff >= p_ff) begin
                  mode_in = MODE_SMOOTH;
                  bars_in = p_ff;
               end else if (({1'b0, bars_ff} + (wrsi_pkg::PERIOD_BITS + 1)'(1))
                            < {1'b0, p_ff}) begin
                  mode_in = MODE_ACC;
                  bars_in = bars_ff + wrsi_pkg::PERIOD_BITS'(1);
               end else begin
                  mode_in = MODE_FIRST;
                  bars_in = p_ff;
               end
            end
         end
         // warmup sums, or divider launch
         ST_LOAD: begin
            if (mode_ff == MODE_ACC) begin
               avg_gain_in  = sum_gain;
               avg_loss_in  = sum_loss;
               bar_valid_in = 1'b0;
               q_in         = '0;
               state_in     = ST_FINISH;
            end else begin
               gain_up_in   = !up_gain[wrsi_pkg::AVG_BITS];
               loss_up_in   = !up_loss[wrsi_pkg::AVG_BITS];
               bar_valid_in = 1'b1;
               state_in     = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_gain_res.done && div_loss_res.done) begin
               state_in = ST_UPDATE;
            end
         end
         // new averages from the quotients
         ST_UPDATE: begin
            if (mode_ff == MODE_FIRST) begin
               avg_gain_in = (div_gain_res.quotient[wrsi_pkg::DIV_BITS-1:wrsi_pkg::AVG_BITS]
                              != '0) ? '1 : q_gain;
               avg_loss_in = (div_loss_res.quotient[wrsi_pkg::DIV_BITS-1:wrsi_pkg::AVG_BITS]
                              != '0) ? '1 : q_loss;
            end else begin
               avg_gain_in = gain_up_ff ? avg_gain_ff + q_gain
                           : avg_gain_ff - q_gain
                             - wrsi_pkg::AVG_BITS'(div_gain_res.remainder != '0);
               avg_loss_in = loss_up_ff ? avg_loss_ff + q_loss
                           : avg_loss_ff - q_loss
                             - wrsi_pkg::AVG_BITS'(div_loss_res.remainder != '0);
            end
            state_in = ST_RSI_INIT;
         end
         // no-loss cases, and halving when gain plus loss overflows
         ST_RSI_INIT: begin
            if (avg_loss_ff == '0) begin
               q_in     = (avg_gain_ff == '0) ? wrsi_pkg::RSI_HALF : wrsi_pkg::RSI_FULL;
               state_in = ST_FINISH;
            end else begin
               g_in     = g_plus_l[wrsi_pkg::AVG_BITS] ? avg_gain_ff >> 1 : avg_gain_ff;
               l_in     = g_plus_l[wrsi_pkg::AVG_BITS] ? avg_loss_ff >> 1 : avg_loss_ff;
               state_in = ST_RSI_SUM;
            end
         end
         ST_RSI_SUM: begin
            s_in     = g_ff + l_ff;
            r_in     = '0;
            q_in     = '0;
            bit_in   = wrsi_pkg::STEP_BITS'(wrsi_pkg::RSI_STEPS - 1);
            state_in = ST_RSI_A;
         end
         // doubling step of the long division
         ST_RSI_A: begin
            r_in = twice_r[wrsi_pkg::AVG_BITS+1] ? {r_ff[wrsi_pkg::AVG_BITS-2:0], 1'b0}
                                                 : twice_r[wrsi_pkg::AVG_BITS-1:0];
            q_in = {q_ff[wrsi_pkg::RSI_BITS-2:0], ~twice_r[wrsi_pkg::AVG_BITS+1]};
            if (wrsi_pkg::RSI_FULL[bit_ff]) begin
               state_in = ST_RSI_B;
            end else if (last_step) begin
               state_in = ST_FINISH;
            end else begin
               bit_in = bit_ff - wrsi_pkg::STEP_BITS'(1);
            end
         end
         // add step of the gain for a set bit of the full scale
         ST_RSI_B: begin
            if (!r_less_l[wrsi_pkg::AVG_BITS]) begin
               r_in = r_less_l[wrsi_pkg::AVG_BITS-1:0];
               q_in = q_ff + wrsi_pkg::RSI_BITS'(1);
            end else begin
               r_in = r_ff + g_ff;
            end
            if (last_step) begin
               state_in = ST_FINISH;
            end else begin
               bit_in   = bit_ff - wrsi_pkg::STEP_BITS'(1);
               state_in = ST_RSI_A;
            end
         end
         // hand the result to the output register once it is free
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_flag_in  = bar_valid_ff;
               rsp_value_in = q_ff;
               rsp_date_in  = date_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      p_ff         <= p_in;
      price_ff     <= price_in;
      prev_ff      <= prev_in;
      gain_ff      <= gain_in;
      loss_ff      <= loss_in;
      date_ff      <= date_in;
      restart_ff   <= restart_in;
      bar_valid_ff <= bar_valid_in;
      gain_up_ff   <= gain_up_in;
      loss_up_ff   <= loss_up_in;
      avg_gain_ff  <= avg_gain_in;
      avg_loss_ff  <= avg_loss_in;
      g_ff         <= g_in;
      l_ff         <= l_in;
      s_ff         <= s_in;
      r_ff         <= r_in;
      q_ff         <= q_in;
      bit_ff       <= bit_in;
      rsp_flag_ff  <= rsp_flag_in;
      rsp_value_ff <= rsp_value_in;
      rsp_date_ff  <= rsp_date_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         period_ff    <= wrsi_pkg::PERIOD_RESET;
         bars_ff      <= '0;
         hist_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         period_ff    <= period_in;
         bars_ff      <= bars_in;
         hist_ff      <= hist_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // channel outputs
   assign req_bus.ready     = (state_ff == ST_IDLE);
   assign csr_bus.ready     = 1'b1;
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.rsi_value = rsp_value_ff;
   assign rsp_bus.rsi_valid = rsp_flag_ff;
   assign rsp_bus.date_out  = rsp_date_ff;

endmodule

// ===== rtl/core/wrsi_checker.sv =====
// port-level checks of the wilder rsi indicator unit, bound to the top level
// depends on wrsi_pkg and wilder_rsi_indicator_unit_macros.svh
`include "wilder_rsi_indicator_unit_macros.svh"

module wrsi_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [wrsi_pkg::RSI_BITS-1:0] rsi_value,
   input logic                          rsi_valid,
   input logic [wrsi_pkg::DATE_BITS-1:0] date_out
);

   // one bar at a time: an accepted bar blocks the input next cycle
   `WRSI_ASSERT(a_busy_after_accept, clock, reset, req_valid && req_ready |=> !req_ready, "input ready right after a transaction")

   // an invalid result carries a zero value
   `WRSI_ASSERT(a_invalid_is_zero, clock, reset, rsp_valid && !rsi_valid |-> rsi_value == '0, "invalid result with nonzero rsi")

   // rsi never passes 100 percent
   `WRSI_ASSERT(a_rsi_range, clock, reset, rsp_valid |-> rsi_value <= wrsi_pkg::RSI_FULL, "rsi above full scale")

   // a stalled result holds
   `WRSI_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsi_value) && $stable(rsi_valid) && $stable(date_out), "stalled result changed")

   // reset empties the output register
   `WRSI_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind wilder_rsi_indicator_unit wrsi_checker u_wrsi_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsi_value (rsp_bus.rsi_value),
   .rsi_valid (rsp_bus.rsi_valid),
   .date_out  (rsp_bus.date_out)
);
